// ===== rtl/tsc_pkg.sv =====
// Shared types and constants of the touch sample calibrator.
// Holds the sample and point word layouts and the divider cell word.
// No dependencies.
`default_nettype none

package tsc_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned PRESS_W = 12;
    localparam int unsigned POINT_W = 16;
    localparam int unsigned COEF_W  = 32;
    // quotient bits kept by the divider; the top bit marks saturation
    localparam int unsigned QUO_W   = 19;
    // partial remainder: divisor magnitude shifted by the top quotient bit
    localparam int unsigned REM_W   = COEF_W + QUO_W;
    // signed numerator width
    localparam int unsigned NUM_W   = 48;
    // signed width of a rotated coordinate before saturation
    localparam int unsigned ROT_W   = QUO_W + 2;

    localparam logic [PRESS_W-1:0] TOUCH_MIN = 12'd70;
    localparam logic [COORD_W:0]   Y_BASE    = 13'd4096;

    // register indexes
    localparam logic [7:0] REG_COEF_A   = 8'd0;
    localparam logic [7:0] REG_COEF_B   = 8'd1;
    localparam logic [7:0] REG_COEF_C   = 8'd2;
    localparam logic [7:0] REG_COEF_D   = 8'd3;
    localparam logic [7:0] REG_COEF_E   = 8'd4;
    localparam logic [7:0] REG_COEF_F   = 8'd5;
    localparam logic [7:0] REG_DIVISOR  = 8'd6;
    localparam logic [7:0] REG_ROTATION = 8'd7;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
        logic [PRESS_W-1:0] raw_pressure;
    } t_sample;

    typedef struct packed {
        logic                      touching;
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [PRESS_W-1:0]        pressure;
        logic                      cal_error;
    } t_point;

    // word handed along the divider chain, both coordinates side by side
    typedef struct packed {
        logic [REM_W-1:0]   rem_x;
        logic [REM_W-1:0]   rem_y;
        logic [QUO_W-1:0]   quo_x;
        logic [QUO_W-1:0]   quo_y;
        logic               neg_x;
        logic               neg_y;
        logic               touching;
        logic               cal_error;
        logic [PRESS_W-1:0] pressure;
    } t_cell;

endpackage

`default_nettype wire

// ===== rtl/touch_sample_calibrator_core.sv =====
// Touch sample calibrator top level: config registers, multiply front end,
// divider chain of tsc_div_cell and rotate/saturate back end.
// Depends on tsc_pkg and tsc_div_cell.
//
// Use: raw samples (x, y, pressure) enter on the in channel, one calibrated
// point leaves on the out channel for each, in order. Both channels are
// valid/ready; a word moves when valid and ready are both high.
// Configuration words go in on the cfg channel (index, data), which is
// always ready; indexes beyond the register list are dropped. Write it only
// while no sample is in flight.
// From accept to output valid a sample passes two multiply/add stages,
// one magnitude stage, 19 divider cells (one quotient bit each) and the
// rotate/saturate output register. One sample is taken every cycle while
// the pipe has room; the divider cells set the latency, not the rate.
// When the receiver stalls, stages fill up one by one behind the output
// register; input ready falls only when every stage holds a word.
// Synchronous reset empties the pipe and loads the identity calibration,
// divisor 1 and no rotation.
`default_nettype none

module touch_sample_calibrator_core #(
    parameter int DISPLAY_WIDTH  = 320,
    parameter int DISPLAY_HEIGHT = 240
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire tsc_pkg::t_sample      i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output tsc_pkg::t_point            o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [7:0]            i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);

    localparam int unsigned QW = tsc_pkg::QUO_W;
    localparam int unsigned RW = tsc_pkg::ROT_W;

    // configuration registers
    logic signed [31:0] r_coef_a, r_coef_b, r_coef_c, r_coef_d, r_coef_e, r_coef_f;
    logic signed [31:0] r_divisor;
    logic [1:0]         r_rotation;
    logic [31:0]        dmag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a   <= 32'sd1;
            r_coef_b   <= 32'sd0;
            r_coef_c   <= 32'sd0;
            r_coef_d   <= 32'sd0;
            r_coef_e   <= 32'sd1;
            r_coef_f   <= 32'sd0;
            r_divisor  <= 32'sd1;
            r_rotation <= tsc_pkg::ROT_0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tsc_pkg::REG_COEF_A:   r_coef_a   <= i_cfg_data;
                tsc_pkg::REG_COEF_B:   r_coef_b   <= i_cfg_data;
                tsc_pkg::REG_COEF_C:   r_coef_c   <= i_cfg_data;
                tsc_pkg::REG_COEF_D:   r_coef_d   <= i_cfg_data;
                tsc_pkg::REG_COEF_E:   r_coef_e   <= i_cfg_data;
                tsc_pkg::REG_COEF_F:   r_coef_f   <= i_cfg_data;
                tsc_pkg::REG_DIVISOR:  r_divisor  <= i_cfg_data;
                tsc_pkg::REG_ROTATION: r_rotation <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // divisor magnitude, 2^31 included
    assign dmag = r_divisor[31] ? 32'(-r_divisor) : 32'(r_divisor);

    // stage 1: products
    logic                         r1_v, rdy1;
    logic signed [44:0]           r1_ax, r1_dx;
    logic signed [45:0]           r1_by, r1_ey;
    logic                         r1_touch, r1_err;
    logic [tsc_pkg::PRESS_W-1:0]  r1_press;
    logic signed [12:0]           s0_x;
    logic signed [13:0]           s0_y;
    logic [12:0]                  s0_yinv;
    logic                         s0_touch;

    assign s0_yinv  = tsc_pkg::Y_BASE - 13'(i_in_data.raw_y);
    assign s0_x     = $signed({1'b0, i_in_data.raw_x});
    assign s0_y     = $signed({1'b0, s0_yinv});
    assign s0_touch = i_in_data.raw_pressure >= tsc_pkg::TOUCH_MIN;

    // stage 2: numerators
    logic                               r2_v, rdy2;
    logic signed [tsc_pkg::NUM_W-1:0]   r2_num_x, r2_num_y;
    logic                               r2_touch, r2_err;
    logic [tsc_pkg::PRESS_W-1:0]        r2_press;

    // stage 3: magnitudes into the divider chain
    logic                               r3_v, rdy3;
    tsc_pkg::t_cell                     r3_word, n3_word;
    logic [tsc_pkg::NUM_W-1:0]          s2_mag_x, s2_mag_y;

    // divider chain links
    logic            c_valid [0:QW];
    logic            c_ready [0:QW];
    tsc_pkg::t_cell  c_word  [0:QW];

    // output stage
    logic            r_out_v, rdy_out;
    tsc_pkg::t_point r_out, n_out;

    assign rdy1 = !r1_v || rdy2;
    assign rdy2 = !r2_v || rdy3;
    assign rdy3 = !r3_v || c_ready[0];
    assign o_in_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_in_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r1_ax    <= r_coef_a * s0_x;
            r1_by    <= r_coef_b * s0_y;
            r1_dx    <= r_coef_d * s0_x;
            r1_ey    <= r_coef_e * s0_y;
            r1_touch <= s0_touch;
            r1_err   <= s0_touch && (r_divisor == 32'sd0);
            r1_press <= s0_touch ? i_in_data.raw_pressure : '0;
        end
        if (rdy2 && r1_v) begin
            r2_num_x <= tsc_pkg::NUM_W'(r1_ax) + tsc_pkg::NUM_W'(r1_by)
                        + tsc_pkg::NUM_W'(r_coef_c);
            r2_num_y <= tsc_pkg::NUM_W'(r1_dx) + tsc_pkg::NUM_W'(r1_ey)
                        + tsc_pkg::NUM_W'(r_coef_f);
            r2_touch <= r1_touch;
            r2_err   <= r1_err;
            r2_press <= r1_press;
        end
        if (rdy3 && r2_v) begin
            r3_word <= n3_word;
        end
    end

    // sign/magnitude split of the numerators
    assign s2_mag_x = r2_num_x[tsc_pkg::NUM_W-1] ? tsc_pkg::NUM_W'(-r2_num_x)
                                                 : tsc_pkg::NUM_W'(r2_num_x);
    assign s2_mag_y = r2_num_y[tsc_pkg::NUM_W-1] ? tsc_pkg::NUM_W'(-r2_num_y)
                                                 : tsc_pkg::NUM_W'(r2_num_y);

    always_comb begin
        n3_word           = '0;
        n3_word.rem_x     = tsc_pkg::REM_W'(s2_mag_x);
        n3_word.rem_y     = tsc_pkg::REM_W'(s2_mag_y);
        n3_word.neg_x     = r2_num_x[tsc_pkg::NUM_W-1] ^ r_divisor[31];
        n3_word.neg_y     = r2_num_y[tsc_pkg::NUM_W-1] ^ r_divisor[31];
        n3_word.touching  = r2_touch;
        n3_word.cal_error = r2_err;
        n3_word.pressure  = r2_press;
    end

    // divider chain, top quotient bit first
    assign c_valid[0]  = r3_v;
    assign c_word[0]   = r3_word;
    assign c_ready[QW] = rdy_out;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        tsc_div_cell #(
            .STEP (QW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_dmag  (dmag),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_word  (c_word[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_word  (c_word[k+1])
        );
    end

    function automatic logic signed [tsc_pkg::POINT_W-1:0] sat16(
        input logic signed [RW-1:0] v
    );
        logic signed [tsc_pkg::POINT_W-1:0] r;
        if (v > RW'(32767)) r = 16'sh7fff;
        else if (v < -RW'(32768)) r = -16'sh8000;
        else r = v[tsc_pkg::POINT_W-1:0];
        return r;
    endfunction

    // quotient sign, rotation and saturation
    logic [QW-1:0]          mag_x, mag_y;
    logic signed [RW-1:0]   cx, cy, px, py, wd, ht;
    tsc_pkg::t_cell         w;

    assign w     = c_word[QW];
    assign mag_x = w.quo_x[QW-1] ? QW'(1) << (QW - 1) : {1'b0, w.quo_x[QW-2:0]};
    assign mag_y = w.quo_y[QW-1] ? QW'(1) << (QW - 1) : {1'b0, w.quo_y[QW-2:0]};
    assign cx    = w.neg_x ? -$signed(RW'(mag_x)) : $signed(RW'(mag_x));
    assign cy    = w.neg_y ? -$signed(RW'(mag_y)) : $signed(RW'(mag_y));
    assign wd    = RW'(DISPLAY_WIDTH);
    assign ht    = RW'(DISPLAY_HEIGHT);

    always_comb begin
        case (r_rotation)
            tsc_pkg::ROT_90: begin
                px = cy;
                py = wd - cx;
            end
            tsc_pkg::ROT_180: begin
                px = wd - cx;
                py = ht - cy;
            end
            tsc_pkg::ROT_270: begin
                px = ht - cy;
                py = cx;
            end
            default: begin
                px = cx;
                py = cy;
            end
        endcase
        n_out           = '0;
        n_out.touching  = w.touching;
        n_out.pressure  = w.pressure;
        n_out.cal_error = w.cal_error;
        if (w.touching && !w.cal_error) begin
            n_out.point_x = sat16(px);
            n_out.point_y = sat16(py);
        end
    end

    assign rdy_out = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (rdy_out) begin
            r_out_v <= c_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out && c_valid[QW]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // input stalls only when the whole pipe is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && r1_v && r3_v))
        else $error("input stalled with room in the pipe");

    // an error, a coordinate or a pressure only comes with a touch
    a_no_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.touching) |->
        (!o_out_data.cal_error && o_out_data.point_x == 16'sd0
         && o_out_data.point_y == 16'sd0 && o_out_data.pressure == '0))
        else $error("non-touch point carries data");

    // a held output word does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

    // error flag forces zero coordinates
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.cal_error) |->
        (o_out_data.touching && o_out_data.point_x == 16'sd0
         && o_out_data.point_y == 16'sd0))
        else $error("calibration error with non-zero point");

endmodule

`default_nettype wire

// ===== rtl/tsc_div_cell.sv =====
// One restoring division step for both coordinates, with its own stage.
// Depends on tsc_pkg for the cell word.
`default_nettype none

module tsc_div_cell #(
    parameter int unsigned STEP = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [tsc_pkg::COEF_W-1:0]  i_dmag,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire tsc_pkg::t_cell              i_word,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output tsc_pkg::t_cell                   o_word
);

    logic                          r_valid;
    tsc_pkg::t_cell                r_word;
    tsc_pkg::t_cell                n_word;
    logic [tsc_pkg::REM_W-1:0]     dsh;

    assign dsh = tsc_pkg::REM_W'(i_dmag) << STEP;

    // subtract the shifted divisor where it fits and set this quotient bit
    always_comb begin
        n_word = i_word;
        if (i_word.rem_x >= dsh) begin
            n_word.rem_x       = i_word.rem_x - dsh;
            n_word.quo_x[STEP] = 1'b1;
        end
        if (i_word.rem_y >= dsh) begin
            n_word.rem_y       = i_word.rem_y - dsh;
            n_word.quo_y[STEP] = 1'b1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ===== tb/touch_sample_calibrator_core_tb.sv =====
// Testbench for touch_sample_calibrator_core: directed table then random samples
// checked against a predictor of the affine calibration, rotation and saturation.
// Depends on tsc_pkg and the core RTL.
`default_nettype none

module touch_sample_calibrator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DISP_W      = 320;
    localparam int DISP_H      = 240;
    localparam int PIPE_CYCLES = 30;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 9;
    localparam int PHASE_ITEMS = 100;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    tsc_pkg::t_sample i_in_data   = '0;
    logic             i_out_ready = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [7:0]       i_cfg_index = '0;
    logic [31:0]      i_cfg_data  = '0;
    logic             o_in_ready, o_out_valid, o_cfg_ready;
    tsc_pkg::t_point  o_out_data;

    touch_sample_calibrator_core #(
        .DISPLAY_WIDTH (DISP_W),
        .DISPLAY_HEIGHT(DISP_H)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // calibration copy held by the predictor
    longint cal_a = 1, cal_b = 0, cal_c = 0, cal_d = 0, cal_e = 1, cal_f = 0, cal_div = 1;
    logic [1:0] cal_rot = tsc_pkg::ROT_0;

    tsc_pkg::t_point pending_points[$];
    int     n_errors  = 0;
    int     n_sent    = 0;
    int     cycles    = 0;
    bit     no_idle   = 1'b0;
    int     hold_cnt  = 0;
    bit     hold_done = 1'b0;

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // expected point for one sample under the current calibration
    function automatic tsc_pkg::t_point calibrate_point(tsc_pkg::t_sample s);
        longint x, y, cx, cy, px, py;
        tsc_pkg::t_point r;
        r = '0;
        if (s.raw_pressure < tsc_pkg::TOUCH_MIN) return r;
        r.touching = 1'b1;
        r.pressure = s.raw_pressure;
        if (cal_div == 0) begin
            r.cal_error = 1'b1;
            return r;
        end
        x  = longint'(s.raw_x);
        y  = 64'sd4096 - longint'(s.raw_y);
        cx = (cal_a * x + cal_b * y + cal_c) / cal_div;
        cy = (cal_d * x + cal_e * y + cal_f) / cal_div;
        case (cal_rot)
            tsc_pkg::ROT_90: begin
                px = cy;
                py = DISP_W - cx;
            end
            tsc_pkg::ROT_180: begin
                px = DISP_W - cx;
                py = DISP_H - cy;
            end
            tsc_pkg::ROT_270: begin
                px = DISP_H - cy;
                py = cx;
            end
            default: begin
                px = cx;
                py = cy;
            end
        endcase
        r.point_x = clamp16(px);
        r.point_y = clamp16(py);
        return r;
    endfunction

    // one sample word on the input channel
    task automatic send_sample(tsc_pkg::t_sample s, bit typed, tsc_pkg::t_point typed_pt);
        while (!no_idle && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        pending_points.push_back(typed ? typed_pt : calibrate_point(s));
        n_sent++;
    endtask

    // wait until every point is out, then let the pipe settle
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tsc_pkg::REG_COEF_A:   cal_a   = longint'($signed(data));
            tsc_pkg::REG_COEF_B:   cal_b   = longint'($signed(data));
            tsc_pkg::REG_COEF_C:   cal_c   = longint'($signed(data));
            tsc_pkg::REG_COEF_D:   cal_d   = longint'($signed(data));
            tsc_pkg::REG_COEF_E:   cal_e   = longint'($signed(data));
            tsc_pkg::REG_COEF_F:   cal_f   = longint'($signed(data));
            tsc_pkg::REG_DIVISOR:  cal_div = longint'($signed(data));
            tsc_pkg::REG_ROTATION: cal_rot = data[1:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_coef(int kind);
        case (kind)
            0: return 32'($signed($urandom_range(4000)) - 2000);
            1: return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic tsc_pkg::t_sample random_sample();
        tsc_pkg::t_sample s;
        s.raw_x = 12'($urandom);
        s.raw_y = 12'($urandom);
        s.raw_pressure = ($urandom_range(9) == 0) ? 12'($urandom_range(69))
                                                   : 12'($urandom_range(4095, 70));
        return s;
    endfunction

    typedef struct {
        bit               is_cfg;
        logic [7:0]       idx;
        logic [31:0]      data;
        tsc_pkg::t_sample s;
        bit               typed;
        tsc_pkg::t_point  pt;
    } t_row;

    t_row rows[$];

    // receiver: random stalls, one long hold-off to fill the pipe
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && n_sent >= 400) begin
            hold_done   <= 1'b1;
            hold_cnt    <= 300;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    task automatic report(string what, longint want, longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        n_errors++;
    endtask

    // output checker
    always @(posedge i_clk) begin
        tsc_pkg::t_point want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected point, expected none, actual %h", $time, o_out_data);
                n_errors++;
            end else begin
                want = pending_points.pop_front();
                if (o_out_data.touching != want.touching)
                    report("touching", want.touching, o_out_data.touching);
                if (o_out_data.point_x != want.point_x)
                    report("point_x", want.point_x, o_out_data.point_x);
                if (o_out_data.point_y != want.point_y)
                    report("point_y", want.point_y, o_out_data.point_y);
                if (o_out_data.pressure != want.pressure)
                    report("pressure", want.pressure, o_out_data.pressure);
                if (o_out_data.cal_error != want.cal_error)
                    report("cal_error", want.cal_error, o_out_data.cal_error);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("touch_sample_calibrator_core_tb failed");
            $finish;
        end
    end

    initial begin
        int kind;
        // directed table: typed points only where obvious
        rows.push_back('{0, 0, 0, '{12'hfff, 12'hfff, 12'd0}, 1, '0});
        rows.push_back('{0, 0, 0, '{12'hfff, 12'hfff, 12'd69}, 1, '0});
        rows.push_back('{0, 0, 0, '{12'd0, 12'd0, 12'd70}, 1,
                         '{1'b1, 16'sd0, 16'sd4096, 12'd70, 1'b0}});
        rows.push_back('{0, 0, 0, '{12'hfff, 12'hfff, 12'hfff}, 1,
                         '{1'b1, 16'sd4095, 16'sd1, 12'hfff, 1'b0}});
        rows.push_back('{0, 0, 0, '{12'hfff, 12'd0, 12'hfff}, 1,
                         '{1'b1, 16'sd4095, 16'sd4096, 12'hfff, 1'b0}});
        rows.push_back('{1, tsc_pkg::REG_DIVISOR, 32'd0, '0, 0, '0});
        rows.push_back('{0, 0, 0, '{12'd123, 12'd456, 12'd100}, 1,
                         '{1'b1, 16'sd0, 16'sd0, 12'd100, 1'b1}});
        rows.push_back('{0, 0, 0, '{12'd123, 12'd456, 12'd50}, 1, '0});
        rows.push_back('{1, tsc_pkg::REG_DIVISOR, 32'd1, '0, 0, '0});
        rows.push_back('{1, tsc_pkg::REG_ROTATION, 32'(tsc_pkg::ROT_90), '0, 0, '0});
        rows.push_back('{0, 0, 0, '{12'd10, 12'd4000, 12'd200}, 0, '0});
        rows.push_back('{1, tsc_pkg::REG_ROTATION, 32'(tsc_pkg::ROT_180), '0, 0, '0});
        rows.push_back('{0, 0, 0, '{12'd300, 12'd20, 12'd900}, 0, '0});
        rows.push_back('{1, tsc_pkg::REG_ROTATION, 32'(tsc_pkg::ROT_270), '0, 0, '0});
        rows.push_back('{0, 0, 0, '{12'd77, 12'd3000, 12'd71}, 0, '0});
        rows.push_back('{1, tsc_pkg::REG_COEF_A, 32'h7fff_ffff, '0, 0, '0});
        rows.push_back('{0, 0, 0, '{12'hfff, 12'd5, 12'd800}, 0, '0});
        rows.push_back('{1, tsc_pkg::REG_COEF_A, 32'h8000_0000, '0, 0, '0});
        rows.push_back('{0, 0, 0, '{12'hfff, 12'd5, 12'd800}, 0, '0});
        // index past the register list is dropped
        rows.push_back('{1, 8'hff, 32'h1234_5678, '0, 0, '0});
        rows.push_back('{0, 0, 0, '{12'd1, 12'd2, 12'd3000}, 0, '0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                drain_pipe();
                write_reg(rows[r].idx, rows[r].data);
            end else begin
                send_sample(rows[r].s, rows[r].typed, rows[r].pt);
            end
        end

        // random phases, each with its own calibration
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_pipe();
            kind = ph % 3;
            no_idle = (ph == 3);
            write_reg(tsc_pkg::REG_COEF_A, pick_coef(kind));
            write_reg(tsc_pkg::REG_COEF_B, pick_coef(kind));
            write_reg(tsc_pkg::REG_COEF_C, pick_coef(kind));
            write_reg(tsc_pkg::REG_COEF_D, pick_coef(kind));
            write_reg(tsc_pkg::REG_COEF_E, pick_coef(kind));
            write_reg(tsc_pkg::REG_COEF_F, pick_coef(kind));
            if (ph == 5)
                write_reg(tsc_pkg::REG_DIVISOR, 32'd0);
            else if (kind == 2)
                write_reg(tsc_pkg::REG_DIVISOR, $urandom);
            else if (kind == 1)
                write_reg(tsc_pkg::REG_DIVISOR,
                          ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000);
            else
                write_reg(tsc_pkg::REG_DIVISOR,
                          32'($signed($urandom_range(32)) - 16) | 32'd1);
            write_reg(tsc_pkg::REG_ROTATION, $urandom);
            write_reg(8'($urandom_range(255, 8)), $urandom);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(random_sample(), 1'b0, '0);
        end

        no_idle = 1'b0;
        drain_pipe();
        if (n_errors == 0) begin
            $display("touch_sample_calibrator_core_tb passed");
        end else begin
            $display("touch_sample_calibrator_core_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
